[hw/rtl/assert_macros.svh]
// assertion helpers used by prq_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on a named clock with an active-low reset
`define PRQ_ASSERT_ON(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("checker assertion failed");

// same, on the house clock and reset names
`define PRQ_ASSERT(label, prop) \
  `PRQ_ASSERT_ON(label, clk_i, rst_ni, prop)

`endif

[hw/rtl/prq_pkg.sv]
// types and codes for the pending request queue
// no dependencies
package prq_pkg;

  localparam int JOB_W   = 16;
  localparam int AMT_W   = 16;
  localparam int CONN_W  = 8;
  localparam int TOTAL_W = 21;
  localparam int ENTRY_W = JOB_W + AMT_W + CONN_W + 1;

  localparam logic [1:0] CMD_ENQ      = 2'd0;
  localparam logic [1:0] CMD_DEQ      = 2'd1;
  localparam logic [1:0] CMD_DEL_CONN = 2'd2;
  localparam logic [1:0] CMD_DEL_JOB  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [JOB_W-1:0]  job;
    logic [AMT_W-1:0]  amount;
    logic [CONN_W-1:0] conn;
    logic              origin;
  } entry_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [JOB_W-1:0]  req_job;
    logic [AMT_W-1:0]  req_amount;
    logic [CONN_W-1:0] req_conn;
    logic              req_origin;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              head_valid;
    logic [JOB_W-1:0]  head_job;
    logic [AMT_W-1:0]  head_amount;
    logic [CONN_W-1:0] head_conn;
    logic              head_origin;
    logic [19:0]       total_amount;
    logic [4:0]        entry_count;
  } rsp_t;

  // controls for the shared key compare and total subtract unit
  typedef struct packed {
    logic              by_conn;
    logic              force_hit;
    logic [JOB_W-1:0]  key_job;
    logic [CONN_W-1:0] key_conn;
  } match_ctl_t;

endpackage

[hw/rtl/prq_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module prq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/prq_match.sv]
// shared key compare and running total subtract unit
// depends on prq_pkg
module prq_match (
  input  prq_pkg::match_ctl_t               ctl_i,
  input  prq_pkg::entry_t                   entry_i,
  input  logic [prq_pkg::TOTAL_W-1:0]       total_i,
  output logic                              hit_o,
  output logic [prq_pkg::TOTAL_W-1:0]       total_o
);
  import prq_pkg::*;

  logic key_eq;

  always_comb begin
    key_eq  = ctl_i.by_conn ? (entry_i.conn == ctl_i.key_conn)
                            : (entry_i.job == ctl_i.key_job);
    hit_o   = ctl_i.force_hit | key_eq;
    total_o = hit_o ? (total_i - TOTAL_W'(entry_i.amount)) : total_i;
  end

endmodule

[hw/rtl/pending_request_fifo_keyed_removal.sv]
// ordered request queue with keyed removal, one command at a time
// an enqueue or a rejected command goes straight to the result state; a dequeue first
// reads and removes the head, a keyed delete first scans and compacts all queued entries
// the input stalls until the result is registered, which waits while the output is stalled
// reset clears count, total and the head and tail pointers; the entry ram is not cleared
module pending_request_fifo_keyed_removal #(
  parameter int DEPTH = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  prq_pkg::req_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output prq_pkg::rsp_t   out_data_o
);
  import prq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEQ  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    wrap_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [1:0]         state_q, state_d;
  logic [AW-1:0]      hd_ptr_q, hd_ptr_d;
  logic [AW-1:0]      tl_ptr_q, tl_ptr_d;
  logic [CW-1:0]      count_q, count_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [AW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [AW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [CW-1:0]      rd_cnt_q, rd_cnt_d;
  logic [CW-1:0]      keep_q, keep_d;
  logic               rvalid_q, rvalid_d;
  logic               out_valid_q, out_valid_d;
  match_ctl_t         ctl_q, ctl_d;
  logic [1:0]         status_q, status_d;
  logic               hv_q, hv_d;
  entry_t             res_q, res_d;
  rsp_t               out_q, out_d;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_raddr;
  entry_t             ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;
  entry_t             ram_rdata;
  match_ctl_t         match_ctl;
  logic               match_hit;
  logic [TOTAL_W-1:0] match_total;
  logic [31:0]        count_ext;

  prq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);

  prq_match u_match (
    .ctl_i  (match_ctl),
    .entry_i(ram_rdata),
    .total_i(total_q),
    .hit_o  (match_hit),
    .total_o(match_total)
  );

  always_comb begin
    match_ctl           = ctl_q;
    // a dequeue always removes the head, whatever its key
    match_ctl.force_hit = (state_q == S_DEQ);
  end

  assign count_ext = 32'(count_q);

  always_comb begin
    state_d     = state_q;
    hd_ptr_d    = hd_ptr_q;
    tl_ptr_d    = tl_ptr_q;
    count_d     = count_q;
    total_d     = total_q;
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    rd_cnt_d    = rd_cnt_q;
    keep_d      = keep_q;
    rvalid_d    = rvalid_q;
    ctl_d       = ctl_q;
    status_d    = status_q;
    hv_d        = hv_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & out_stall_i;
    ram_we      = 1'b0;
    ram_waddr   = tl_ptr_q;
    ram_wdata   = ram_rdata;
    ram_raddr   = rd_ptr_q;

    case (state_q)
      S_IDLE: begin
        ram_raddr = hd_ptr_q;
        if (in_valid_i) begin
          status_d = ST_OK;
          hv_d     = 1'b0;
          res_d    = '0;
          case (in_data_i.command)
            CMD_ENQ: begin
              if (count_q == CW'(DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                ram_we           = 1'b1;
                ram_wdata.job    = in_data_i.req_job;
                ram_wdata.amount = in_data_i.req_amount;
                ram_wdata.conn   = in_data_i.req_conn;
                ram_wdata.origin = in_data_i.req_origin;
                tl_ptr_d         = wrap_inc(tl_ptr_q);
                count_d          = count_q + 1'b1;
                total_d          = total_q + TOTAL_W'(in_data_i.req_amount);
              end
              state_d = S_FIN;
            end
            CMD_DEQ: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
                state_d  = S_FIN;
              end else begin
                state_d = S_DEQ;
              end
            end
            default: begin
              ctl_d.by_conn   = (in_data_i.command == CMD_DEL_CONN);
              ctl_d.force_hit = 1'b0;
              ctl_d.key_job   = in_data_i.req_job;
              ctl_d.key_conn  = in_data_i.req_conn;
              rd_ptr_d        = hd_ptr_q;
              wr_ptr_d        = hd_ptr_q;
              rd_cnt_d        = '0;
              keep_d          = '0;
              rvalid_d        = 1'b0;
              state_d         = S_SCAN;
            end
          endcase
        end
      end
      S_DEQ: begin
        hv_d     = 1'b1;
        res_d    = ram_rdata;
        hd_ptr_d = wrap_inc(hd_ptr_q);
        count_d  = count_q - 1'b1;
        total_d  = match_total;
        state_d  = S_FIN;
      end
      S_SCAN: begin
        // entry read last cycle: drop on a key hit, else compact it down
        if (rvalid_q) begin
          if (match_hit) begin
            total_d = match_total;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = wr_ptr_q;
            wr_ptr_d  = wrap_inc(wr_ptr_q);
            keep_d    = keep_q + 1'b1;
          end
        end
        if (rd_cnt_q != count_q) begin
          rd_ptr_d = wrap_inc(rd_ptr_q);
          rd_cnt_d = rd_cnt_q + 1'b1;
          rvalid_d = 1'b1;
        end else begin
          rvalid_d = 1'b0;
          if (!rvalid_q) begin
            count_d  = keep_q;
            tl_ptr_d = wr_ptr_q;
            state_d  = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.status       = status_q;
          out_d.head_valid   = hv_q;
          out_d.head_job     = res_q.job;
          out_d.head_amount  = res_q.amount;
          out_d.head_conn    = res_q.conn;
          out_d.head_origin  = res_q.origin;
          out_d.total_amount = total_q[19:0];
          out_d.entry_count  = count_ext[4:0];
          out_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hd_ptr_q    <= '0;
      tl_ptr_q    <= '0;
      count_q     <= '0;
      total_q     <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hd_ptr_q    <= hd_ptr_d;
      tl_ptr_q    <= tl_ptr_d;
      count_q     <= count_d;
      total_q     <= total_d;
      rvalid_q    <= rvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q <= rd_ptr_d;
    wr_ptr_q <= wr_ptr_d;
    rd_cnt_q <= rd_cnt_d;
    keep_q   <= keep_d;
    ctl_q    <= ctl_d;
    status_q <= status_d;
    hv_q     <= hv_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[hw/rtl/prq_checker.sv]
// port-level checks for the pending request queue, bound to the top level
// depends on prq_pkg and assert_macros.svh
`include "assert_macros.svh"

module prq_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_i,
  input logic          out_valid_i,
  input logic          out_stall_i,
  input prq_pkg::rsp_t out_data_i
);
  import prq_pkg::*;

  `PRQ_ASSERT(a_out_hold, out_valid_i && out_stall_i |=> out_valid_i && $stable(out_data_i))
  // one command at a time: busy right after an input transfer
  `PRQ_ASSERT(a_busy_after_xfer, in_valid_i && !in_stall_i |=> in_stall_i)
  `PRQ_ASSERT(a_head_ok, out_valid_i && out_data_i.head_valid |-> out_data_i.status == ST_OK)
  `PRQ_ASSERT(a_empty_result, out_valid_i && out_data_i.status == ST_EMPTY |-> out_data_i.entry_count == '0 && !out_data_i.head_valid)
  `PRQ_ASSERT(a_full_no_head, out_valid_i && out_data_i.status == ST_FULL |-> !out_data_i.head_valid)

endmodule

bind pending_request_fifo_keyed_removal prq_checker u_prq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_i (in_stall_o),
  .out_valid_i(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_i (out_data_o)
);

[tb/prq_result_checker.sv]
// checker for the pending request queue: mirrors the queue, predicts each result, compares
// depends on prq_pkg for the request and result structs and the command and status codes
module prq_result_checker #(
  parameter int DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  prq_pkg::req_t in_data_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  prq_pkg::rsp_t out_data_i,
  output int            mismatch_count_o,
  output int            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import prq_pkg::*;

  entry_t               shadow_q[$];
  logic [TOTAL_W-1:0]   shadow_total;
  rsp_t                 expected_rsp_q[$];

  // runs one command on the shadow queue and returns the result it should give
  function automatic rsp_t apply_command(input req_t r);
    rsp_t   rsp;
    entry_t e;
    entry_t kept[$];
    bit     hit;
    rsp = '0;
    rsp.status = ST_OK;
    case (r.command)
      CMD_ENQ: begin
        if (shadow_q.size() >= DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          e.job    = r.req_job;
          e.amount = r.req_amount;
          e.conn   = r.req_conn;
          e.origin = r.req_origin;
          shadow_q.push_back(e);
          shadow_total = shadow_total + r.req_amount;
        end
      end
      CMD_DEQ: begin
        if (shadow_q.size() == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          e = shadow_q.pop_front();
          rsp.head_valid  = 1'b1;
          rsp.head_job    = e.job;
          rsp.head_amount = e.amount;
          rsp.head_conn   = e.conn;
          rsp.head_origin = e.origin;
          shadow_total = shadow_total - e.amount;
        end
      end
      default: begin
        // keyed delete keeps the order of the survivors
        foreach (shadow_q[k]) begin
          hit = (r.command == CMD_DEL_CONN) ? (shadow_q[k].conn == r.req_conn)
                                            : (shadow_q[k].job == r.req_job);
          if (hit) begin
            shadow_total = shadow_total - shadow_q[k].amount;
          end else begin
            kept.push_back(shadow_q[k]);
          end
        end
        shadow_q = kept;
      end
    endcase
    rsp.total_amount = shadow_total[19:0];
    rsp.entry_count  = 5'(shadow_q.size());
    return rsp;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
      mismatch_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      shadow_q.delete();
      expected_rsp_q.delete();
      shadow_total = '0;
      mismatch_count_o = 0;
      pending_o = 0;
    end else begin
      // result side first: a result can never belong to the transfer at this edge
      if (out_valid_i && !out_stall_i) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t ns: result with nothing expected, got 0x%0h", $time, out_data_i);
          mismatch_count_o++;
        end else begin
          want = expected_rsp_q.pop_front();
          check_field("status", want.status, out_data_i.status);
          check_field("head_valid", want.head_valid, out_data_i.head_valid);
          check_field("head_job", want.head_job, out_data_i.head_job);
          check_field("head_amount", want.head_amount, out_data_i.head_amount);
          check_field("head_conn", want.head_conn, out_data_i.head_conn);
          check_field("head_origin", want.head_origin, out_data_i.head_origin);
          check_field("total_amount", want.total_amount, out_data_i.total_amount);
          check_field("entry_count", want.entry_count, out_data_i.entry_count);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_rsp_q.push_back(apply_command(in_data_i));
      end
      pending_o = expected_rsp_q.size();
    end
  end

endmodule

[tb/pending_request_fifo_keyed_removal_tb.sv]
// top of the pending request queue testbench: clock, reset, stimulus and verdict
// depends on prq_pkg, the queue block and prq_result_checker
module pending_request_fifo_keyed_removal_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import prq_pkg::*;

  localparam int DEPTH        = 16;
  localparam int RANDOM_ITEMS = 1225;
  localparam int HOLD_AT      = 400;
  localparam int BURST_LEN    = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int PAUSE_AT     = 800;
  localparam int DRAIN_CYCLES = 40;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_e;

  bit   clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  req_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  rsp_t out_data_o;
  int   mismatches;
  int   pending;
  bit   hold_req = 1'b0;

  logic [JOB_W-1:0]  job_pool[8];
  logic [CONN_W-1:0] conn_pool[6];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  pending_request_fifo_keyed_removal #(.DEPTH(DEPTH)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  prq_result_checker #(.DEPTH(DEPTH)) result_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .in_data_i        (in_data_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_data_i       (out_data_o),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  function automatic req_t mk_req(input logic [1:0] cmd, input logic [JOB_W-1:0] job,
                                  input logic [AMT_W-1:0] amt,
                                  input logic [CONN_W-1:0] conn, input logic org);
    req_t r;
    r.command    = cmd;
    r.req_job    = job;
    r.req_amount = amt;
    r.req_conn   = conn;
    r.req_origin = org;
    return r;
  endfunction

  // keys mostly come from small pools so that keyed deletes find matches
  function automatic req_t pick_req(input mix_e mix);
    req_t        r;
    int unsigned roll;
    int unsigned enq_w;
    int unsigned deq_w;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  begin enq_w = 70; deq_w = 10; end
      MIX_DRAIN: begin enq_w = 25; deq_w = 45; end
      default:   begin enq_w = 40; deq_w = 25; end
    endcase
    if (roll < enq_w) begin
      r.command = CMD_ENQ;
    end else if (roll < enq_w + deq_w) begin
      r.command = CMD_DEQ;
    end else if (roll[0]) begin
      r.command = CMD_DEL_CONN;
    end else begin
      r.command = CMD_DEL_JOB;
    end
    r.req_job  = ($urandom_range(0, 9) < 7) ? job_pool[$urandom_range(0, 7)]
                                            : JOB_W'($urandom);
    r.req_conn = ($urandom_range(0, 9) < 7) ? conn_pool[$urandom_range(0, 5)]
                                            : CONN_W'($urandom);
    case ($urandom_range(0, 7))
      0:       r.req_amount = '0;
      1:       r.req_amount = '1;
      default: r.req_amount = AMT_W'($urandom);
    endcase
    r.req_origin = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // offer one request and hold it until the transfer, then idle for the given gap
  task automatic send(input req_t r, input int unsigned gap);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // result side back-pressure, including one long hold-off on request
  initial begin
    int unsigned roll;
    int unsigned len;
    logic        stall_val;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req  = 1'b0;
        stall_val = 1'b1;
        len       = HOLD_CYCLES;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          stall_val = 1'b0;
          len = $urandom_range(1, 8);
        end else if (roll < 85) begin
          stall_val = 1'b1;
          len = $urandom_range(1, 3);
        end else if (roll < 95) begin
          stall_val = 1'b0;
          len = $urandom_range(30, 80);
        end else begin
          stall_val = 1'b1;
          len = $urandom_range(20, 60);
        end
      end
      out_stall_i <= stall_val;
      repeat (len) @(negedge clk_i);
    end
  end

  initial begin
    int unsigned gap;
    mix_e        mix;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    rst_ni     = 1'b0;
    foreach (job_pool[k]) job_pool[k] = JOB_W'($urandom);
    foreach (conn_pool[k]) conn_pool[k] = CONN_W'($urandom);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty queue cases
    send(mk_req(CMD_DEQ, 16'h1234, 16'h5678, 8'h9A, 1'b1), pick_gap());
    send(mk_req(CMD_DEL_CONN, 16'h0000, 16'h0000, 8'hFF, 1'b0), pick_gap());
    send(mk_req(CMD_DEL_JOB, 16'h0000, 16'hFFFF, 8'h00, 1'b1), pick_gap());
    // fill to the brim with maximal amounts, then one more
    for (int i = 0; i < DEPTH; i++) begin
      send(mk_req(CMD_ENQ, (i % 3 == 0) ? 16'hFFFF : JOB_W'(i - 1), 16'hFFFF,
                  (i % 4 == 0) ? 8'hFF : 8'h00, 1'(i)), pick_gap());
    end
    send(mk_req(CMD_ENQ, 16'h0000, 16'h0000, 8'h00, 1'b0), pick_gap());
    // keyed deletes with several matches, then one with none
    send(mk_req(CMD_DEL_JOB, 16'hFFFF, 16'h0000, 8'h00, 1'b0), pick_gap());
    send(mk_req(CMD_DEL_CONN, 16'h0000, 16'h0000, 8'hFF, 1'b0), pick_gap());
    send(mk_req(CMD_DEL_CONN, 16'hFFFF, 16'hFFFF, 8'h5A, 1'b1), pick_gap());
    send(mk_req(CMD_DEQ, 16'h0000, 16'h0000, 8'h00, 1'b0), pick_gap());
    send(mk_req(CMD_ENQ, 16'h0000, 16'h0000, 8'h00, 1'b0), pick_gap());

    mix = MIX_EVEN;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) mix = mix_e'($urandom_range(0, 2));
      if (n == HOLD_AT) hold_req = 1'b1;
      // back-to-back offers while the result side is held off
      gap = (n >= HOLD_AT && n < HOLD_AT + BURST_LEN) ? 0 : pick_gap();
      if ((n == PAUSE_AT - 1 || n == RANDOM_ITEMS - 1) && gap == 0) gap = 1;
      send(pick_req(mix), gap);
      if (n == PAUSE_AT - 1) begin
        while (pending != 0) @(negedge clk_i);
      end
    end

    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #3000000;
    $display("tb: failure");
    $finish;
  end

endmodule
